// ===== rtl/seq_pkg.sv =====
// shared types and codes for the sorted event queue
// no dependencies
package seq_pkg;

    // request opcode carried on the mode input
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_SCAN = 3'b100
    } seq_state_t;

endpackage

// ===== rtl/sorted_event_queue.sv =====
// sorted event queue: future-event list in one circular memory, earliest first
// depends on seq_pkg
//
// usage
//   a request is taken at a rising edge where start is high and busy is low;
//   mode selects push (store event_code at event_time) or pop (remove the
//   earliest entry). every request gives one result, shown for one cycle with
//   done high; the receiver cannot hold it off.
//   entries with equal times leave in arrival order.
// request handling
//   pop of a held entry: the head entry is read into a register at the request
//   edge, busy is high in the pop state, and done is raised as it ends.
//   pop on an empty store or push into a full store: done is raised at the
//   request edge itself, busy stays low; overflow flags the dropped push.
//   push: the scan walks down from the tail; each held entry later than the
//   new time is read and moved up one place per cycle through the single read
//   and write port, and done is raised at the edge that writes the new entry.
//   a new request may be given while done is high.
// reset
//   rst_n clears the fill count and the head pointer; the memory is not
//   cleared; slots not yet written may be read, but their data is not used.
module sorted_event_queue #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 32,
    parameter int CODE_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic [CODE_BITS-1:0]         event_code,
    input  logic [TIME_BITS-1:0]         event_time,
    output logic                         done,
    output logic                         pop_valid,
    output logic [CODE_BITS-1:0]         out_code,
    output logic [TIME_BITS-1:0]         out_time,
    output logic                         overflow,
    output logic [$clog2(DEPTH+1)-1:0]   fill_level
);

    import seq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    typedef struct packed {
        logic [TIME_BITS-1:0] tim;
        logic [CODE_BITS-1:0] code;
    } entry_t;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;
    entry_t wr_data;
    logic   wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    seq_state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    entry_t        new_reg, new_next;

    logic                 done_reg, done_next;
    logic                 pop_valid_reg, pop_valid_next;
    logic [CODE_BITS-1:0] out_code_reg, out_code_next;
    logic [TIME_BITS-1:0] out_time_reg, out_time_next;
    logic                 overflow_reg, overflow_next;
    logic [CW-1:0]        fill_level_reg, fill_level_next;

    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail_ptr;
    logic          accept;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == AW'(DEPTH - 1))
            r = '0;
        else
            r = p + AW'(1);
        return r;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        if (p == '0)
            r = AW'(DEPTH - 1);
        else
            r = p - AW'(1);
        return r;
    endfunction

    assign accept = start && (state_reg == ST_IDLE);

    // physical slot just past the last held entry
    assign tail_sum = SW'(head_reg) + SW'(count_reg);
    assign tail_ptr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wptr_next       = wptr_reg;
        rptr_next       = rptr_reg;
        new_next        = new_reg;
        done_next       = 1'b0;
        pop_valid_next  = pop_valid_reg;
        out_code_next   = out_code_reg;
        out_time_next   = out_time_reg;
        overflow_next   = overflow_reg;
        fill_level_next = fill_level_reg;
        wr_en           = 1'b0;
        wr_addr         = wptr_reg;
        wr_data         = new_reg;
        rd_addr         = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next       = 1'b1;
                            pop_valid_next  = 1'b0;
                            out_code_next   = '0;
                            out_time_next   = '0;
                            overflow_next   = 1'b0;
                            fill_level_next = count_reg;
                        end
                        else
                        begin
                            rd_addr    = head_reg;
                            head_next  = ptr_inc(head_reg);
                            count_next = count_reg - CW'(1);
                            state_next = ST_POP;
                        end
                    end
                    else if (count_reg == CW'(DEPTH))
                    begin
                        done_next       = 1'b1;
                        pop_valid_next  = 1'b0;
                        out_code_next   = '0;
                        out_time_next   = '0;
                        overflow_next   = 1'b1;
                        fill_level_next = count_reg;
                    end
                    else
                    begin
                        // walk down from the tail, reading the entry below the hole
                        new_next.tim  = event_time;
                        new_next.code = event_code;
                        wptr_next     = tail_ptr;
                        rptr_next     = ptr_dec(tail_ptr);
                        rd_addr       = ptr_dec(tail_ptr);
                        idx_next      = count_reg;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_POP:
            begin
                done_next       = 1'b1;
                pop_valid_next  = 1'b1;
                out_code_next   = rd_data_reg.code;
                out_time_next   = rd_data_reg.tim;
                overflow_next   = 1'b0;
                fill_level_next = count_reg;
                state_next      = ST_IDLE;
            end

            ST_SCAN:
            begin
                // rd_data_reg holds the entry at rptr_reg; next read issued ahead
                rd_addr = ptr_dec(rptr_reg);
                wr_en   = 1'b1;
                wr_addr = wptr_reg;
                if ((idx_reg != '0) && (rd_data_reg.tim > new_reg.tim))
                begin
                    wr_data   = rd_data_reg;
                    wptr_next = rptr_reg;
                    rptr_next = ptr_dec(rptr_reg);
                    idx_next  = idx_reg - CW'(1);
                end
                else
                begin
                    wr_data         = new_reg;
                    count_next      = count_reg + CW'(1);
                    done_next       = 1'b1;
                    pop_valid_next  = 1'b0;
                    out_code_next   = '0;
                    out_time_next   = '0;
                    overflow_next   = 1'b0;
                    fill_level_next = count_reg + CW'(1);
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        wptr_reg       <= wptr_next;
        rptr_reg       <= rptr_next;
        new_reg        <= new_next;
        pop_valid_reg  <= pop_valid_next;
        out_code_reg   <= out_code_next;
        out_time_reg   <= out_time_next;
        overflow_reg   <= overflow_next;
        fill_level_reg <= fill_level_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign pop_valid  = pop_valid_reg;
    assign out_code   = out_code_reg;
    assign out_time   = out_time_reg;
    assign overflow   = overflow_reg;
    assign fill_level = fill_level_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (fill_level == CW'(DEPTH)))
        else $error("overflow reported below full");

    a_pop_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pop_valid) |-> !overflow)
        else $error("pop and overflow together");

    a_request_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request taken without work or result");

    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= count_reg))
        else $error("insert scan index beyond held entries");

endmodule

// ===== verif/tb.sv =====
// testbench for sorted_event_queue: directed and random push/pop requests with
// a scoreboard that keeps its own sorted copy of the stored events
// depends on seq_pkg and sorted_event_queue
`timescale 1ns / 1ps

module tb;
    import seq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 32;
    localparam int CODE_BITS = 8;
    localparam int FILL_BITS = $clog2(DEPTH + 1);
    localparam int SETTLE_CYCLES = DEPTH + 8;

    typedef struct {
        logic                 pop_valid;
        logic [CODE_BITS-1:0] code;
        logic [TIME_BITS-1:0] tm;
        logic                 overflow;
        logic [FILL_BITS-1:0] fill;
    } queue_result_t;

    class queue_scoreboard;
        logic [TIME_BITS-1:0] held_time[$];
        logic [CODE_BITS-1:0] held_code[$];
        queue_result_t        expected[$];
        int                   mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // work out the result of an accepted request and update the held events
        function void note_request(logic m, logic [CODE_BITS-1:0] c,
                                   logic [TIME_BITS-1:0] t);
            queue_result_t r;
            int pos;
            r = '{1'b0, '0, '0, 1'b0, '0};
            if (m == MODE_PUSH) begin
                if (held_time.size() >= DEPTH) begin
                    r.overflow = 1'b1;
                end
                else begin
                    // equal times stay in arrival order
                    pos = 0;
                    while (pos < held_time.size() && held_time[pos] <= t)
                        pos++;
                    held_time.insert(pos, t);
                    held_code.insert(pos, c);
                end
            end
            else if (held_time.size() > 0) begin
                r.pop_valid = 1'b1;
                r.tm   = held_time.pop_front();
                r.code = held_code.pop_front();
            end
            r.fill = FILL_BITS'(held_time.size());
            expected.push_back(r);
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t want;
            if (expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: valid %0b code %0h time %0h ovf %0b fill %0d",
                             got.pop_valid, got.code, got.tm, got.overflow, got.fill);
                return;
            end
            want = expected.pop_front();
            if (got.pop_valid !== want.pop_valid || got.code !== want.code ||
                got.tm !== want.tm || got.overflow !== want.overflow ||
                got.fill !== want.fill) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp valid %0b code %0h time %0h ovf %0b fill %0d,",
                              " got valid %0b code %0h time %0h ovf %0b fill %0d"},
                             want.pop_valid, want.code, want.tm, want.overflow, want.fill,
                             got.pop_valid, got.code, got.tm, got.overflow, got.fill);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 mode;
    logic [CODE_BITS-1:0] event_code;
    logic [TIME_BITS-1:0] event_time;
    logic                 done;
    logic                 pop_valid;
    logic [CODE_BITS-1:0] out_code;
    logic [TIME_BITS-1:0] out_time;
    logic                 overflow;
    logic [FILL_BITS-1:0] fill_level;

    queue_scoreboard sb = new();

    sorted_event_queue #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS),
        .CODE_BITS (CODE_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .event_code (event_code),
        .event_time (event_time),
        .done       (done),
        .pop_valid  (pop_valid),
        .out_code   (out_code),
        .out_time   (out_time),
        .overflow   (overflow),
        .fill_level (fill_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    // results last one cycle and are taken at the edge that ends it
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{pop_valid, out_code, out_time, overflow, fill_level});
    end

    // one request, after an optional idle gap; returns at the accepting edge
    task automatic send_request(input logic m, input logic [CODE_BITS-1:0] c,
                                input logic [TIME_BITS-1:0] t, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        mode       <= m;
        event_code <= c;
        event_time <= t;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(m, c, t);
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_time(input int style);
        case (style)
            0: return $urandom_range(0, 7);
            1: return $urandom;
            default:
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return {4'($urandom_range(0, 15)), 28'h0};
                    default: return {4'hF, 28'(($urandom))};
                endcase
        endcase
    endfunction

    initial
    begin
        int push_pct;
        int time_style;
        bit quiet;
        int guard;
        logic m;

        rst_n      = 1'b0;
        start      = 1'b0;
        mode       = MODE_PUSH;
        event_code = '0;
        event_time = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, extreme codes and times, ties, full store
        send_request(MODE_POP, 8'h3C, 32'h1234_5678, 0);
        send_request(MODE_PUSH, 8'hFF, 32'hFFFF_FFFF, 0);
        send_request(MODE_PUSH, 8'h00, 32'h0000_0000, 0);
        send_request(MODE_PUSH, 8'h5A, 32'h0000_0000, 0);
        send_request(MODE_PUSH, 8'hA5, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < DEPTH - 4; i++)
            send_request(MODE_PUSH, CODE_BITS'($urandom), 32'd100 + (i % 3), 0);
        send_request(MODE_PUSH, 8'hFF, 32'd7, 0);
        send_request(MODE_PUSH, 8'h81, 32'h8000_0000, 0);
        for (int i = 0; i < 4; i++)
            send_request(MODE_POP, CODE_BITS'($urandom), $urandom, 0);

        // random phases: fill-heavy ones drive toward overflow, drain-heavy ones toward empty
        for (int p = 0; p < 13; p++) begin
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 20;
                default: push_pct = 55;
            endcase
            time_style = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 50; n++) begin
                m = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
                send_request(m, CODE_BITS'($urandom), pick_time(time_style),
                             pick_gap(quiet));
            end
        end
        start <= 1'b0;

        guard = 0;
        while (sb.pending() > 0 && guard < 1000) begin
            @(posedge clk);
            guard++;
        end
        if (sb.pending() > 0) begin
            $display("tb: failure");
            $finish;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
